// ===== hw/rtl/imp_pkg.sv =====
// Package for the incremental multi-pattern matcher.
// Default sizes, request kinds and the sequencer state type.
// No dependencies.
package imp_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned MaxPatterns   = 32;
  localparam int unsigned MaxPatternLen = 8;
  localparam int unsigned CharBits      = 16;

  // Fixed field widths of the stream words
  localparam int unsigned CfgBits = 6;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_LEN,
    ST_OUT
  } imp_state_e;

endpackage

// ===== hw/rtl/imp_char_mem.sv =====
// Pattern character store: one write port, one registered read port.
// Contents are undefined until written.
// Depends on imp_pkg.
module imp_char_mem
  import imp_pkg::*;
#(
  parameter int unsigned Depth = MaxPatterns * MaxPatternLen,
  parameter int unsigned Width = CharBits,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/imp_len_mem.sv =====
// Pattern length store with per-entry valid bits; unwritten entries read zero.
// One write port, one registered read port.
// Depends on imp_pkg.
module imp_len_mem
  import imp_pkg::*;
#(
  parameter int unsigned Depth = MaxPatterns,
  parameter int unsigned Width = 4,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rdata_q;
  logic             rvld_q;

  // Data array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/incremental_multi_pattern_matcher.sv =====
// Incremental multi-pattern matcher top level: sequencer and match datapath.
// Uses imp_pkg, imp_char_mem and imp_len_mem.
//
// Channel   Dir  Handshake                  Word
// s_axis    in   s_axis_tvalid/tready       tuser: req_type; tdata: see port
// m_axis    out  m_axis_tvalid/tready       tdata: see port
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: patterns_in_use
//
// A check word is accepted in idle; then one pattern entry is read from the
// character and length memories per cycle in the scan state, followed by
// drain, decision, length lookup and output. A load word passes through the
// write, length lookup and output states.
// One word is processed at a time; a new word is accepted once the previous
// result is in the output register. Reset empties the length table (valid
// bits) and starts with no match in progress. A stalled output holds the
// sequencer in its last state.
module incremental_multi_pattern_matcher
  import imp_pkg::*;
#(
  parameter int unsigned MAX_PATTERNS    = MaxPatterns,
  parameter int unsigned MAX_PATTERN_LEN = MaxPatternLen,
  parameter int unsigned CHAR_BITS       = CharBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [0] req_type
  input  logic [0:0]         s_axis_tuser,
  // [4:0] pattern_index, [7:5] char_position, [23:8] char_value,
  // [27:24] pattern_length, [31:28] zero
  input  logic [31:0]        s_axis_tdata,
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] still_matching, [1] pattern_found, [6:2] found_index,
  // [10:7] found_length, [15:11] zero
  output logic [15:0]        m_axis_tdata,
  // Configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgBits-1:0] cfg_data_i
);

  localparam int unsigned IW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned CD = MAX_PATTERNS * MAX_PATTERN_LEN;
  localparam int unsigned AW = (CD > 1) ? $clog2(CD) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN_LEN + 1);

  // Input word fields
  logic             in_kind;
  logic [4:0]       in_idx;
  logic [2:0]       in_pos;
  logic [15:0]      in_char;
  logic [3:0]       in_len;
  logic             s_acc;

  assign in_kind = s_axis_tuser[0];
  assign in_idx  = s_axis_tdata[4:0];
  assign in_pos  = s_axis_tdata[7:5];
  assign in_char = s_axis_tdata[23:8];
  assign in_len  = s_axis_tdata[27:24];
  assign s_acc   = s_axis_tvalid & s_axis_tready;

  // Registers
  imp_state_e          state_q, state_d;
  logic [CfgBits-1:0]  cfg_q;
  logic                kind_q, kind_d;
  logic [4:0]          idx_q, idx_d;
  logic [2:0]          lpos_q, lpos_d;
  logic [CHAR_BITS-1:0] ch_q, ch_d;
  logic [3:0]          llen_q, llen_d;
  logic [MAX_PATTERNS-1:0] cand_q, cand_d;
  logic [MAX_PATTERNS-1:0] next_q, next_d;
  logic [LW-1:0]       pos_q, pos_d;
  logic                idle_q, idle_d;
  logic                found_q, found_d;
  logic [IW-1:0]       fent_q, fent_d;
  logic                any_q, any_d;
  logic                fh_q, fh_d;
  logic [IW-1:0]       fi_q, fi_d;
  logic [IW-1:0]       scan_q, scan_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IW-1:0]       ev_idx_q, ev_idx_d;
  logic                out_vld_q, out_vld_d;
  logic [15:0]         out_q, out_d;

  // Memory signals
  logic                 cm_we;
  logic [AW-1:0]        cm_waddr;
  logic [AW-1:0]        cm_raddr;
  logic [CHAR_BITS-1:0] cm_rdata;
  logic                 lm_we;
  logic [IW-1:0]        lm_waddr;
  logic [LW-1:0]        lm_wdata;
  logic [IW-1:0]        lm_raddr;
  logic [LW-1:0]        lm_rdata;

  // Helpers
  logic [31:0]             active;
  logic [MAX_PATTERNS-1:0] start_mask;
  logic                    ld_ok;
  logic                    slot_free;
  logic                    scan_last;
  logic                    ev_cand;
  logic                    ev_hit;
  logic                    ev_fin;

  imp_char_mem #(
    .Depth (CD),
    .Width (CHAR_BITS)
  ) u_char_mem (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (ch_q),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  imp_len_mem #(
    .Depth (MAX_PATTERNS),
    .Width (LW)
  ) u_len_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (lm_we),
    .waddr_i (lm_waddr),
    .wdata_i (lm_wdata),
    .raddr_i (lm_raddr),
    .rdata_o (lm_rdata)
  );

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Starting candidate set: entries below the saturated patterns_in_use
  assign active = (32'(cfg_q) > MAX_PATTERNS) ? 32'(MAX_PATTERNS) : 32'(cfg_q);

  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      start_mask[i] = (32'(i) < active);
    end
  end

  assign ld_ok     = (32'(idx_q) < MAX_PATTERNS);
  assign slot_free = !out_vld_q || m_axis_tready;
  assign scan_last = (scan_q == IW'(MAX_PATTERNS - 1));

  // Compare of the entry whose memory data arrives this cycle
  assign ev_cand = cand_q[ev_idx_q];
  assign ev_hit  = ev_cand && (lm_rdata > pos_q) && (32'(pos_q) < MAX_PATTERN_LEN) &&
                   (cm_rdata == ch_q);
  assign ev_fin  = ev_cand && (lm_rdata == pos_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = (in_kind == REQ_LOAD) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_WRITE:  state_d = ST_LEN;
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_LEN;
      ST_LEN:    state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory control
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cm_we         = (state_q == ST_WRITE) && ld_ok && (32'(lpos_q) < MAX_PATTERN_LEN);
    cm_waddr      = AW'(32'(idx_q) * MAX_PATTERN_LEN + 32'(lpos_q));
    cm_raddr      = AW'(32'(scan_q) * MAX_PATTERN_LEN + 32'(pos_q));
    lm_we         = (state_q == ST_WRITE) && ld_ok;
    lm_waddr      = IW'(idx_q);
    lm_wdata      = (32'(llen_q) > MAX_PATTERN_LEN) ? LW'(MAX_PATTERN_LEN) : LW'(llen_q);
    lm_raddr      = (state_q == ST_SCAN) ? scan_q : fent_q;
  end

  // Datapath
  always_comb begin
    kind_d    = kind_q;
    idx_d     = idx_q;
    lpos_d    = lpos_q;
    ch_d      = ch_q;
    llen_d    = llen_q;
    cand_d    = cand_q;
    next_d    = next_q;
    pos_d     = pos_q;
    idle_d    = idle_q;
    found_d   = found_q;
    fent_d    = fent_q;
    any_d     = any_q;
    fh_d      = fh_q;
    fi_d      = fi_q;
    scan_d    = scan_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_d     = out_q;

    // Latch the word; a check from idle opens a new match attempt
    if (s_acc) begin
      kind_d = in_kind;
      idx_d  = in_idx;
      lpos_d = in_pos;
      ch_d   = CHAR_BITS'(in_char);
      llen_d = in_len;
      any_d  = 1'b0;
      next_d = '0;
      fh_d   = 1'b0;
      fi_d   = '0;
      scan_d = '0;
      if ((in_kind == REQ_CHECK) && idle_q) begin
        cand_d  = start_mask;
        pos_d   = '0;
        found_d = 1'b0;
        idle_d  = 1'b0;
      end
    end

    // Issue one entry read per cycle
    if (state_q == ST_SCAN) begin
      scan_d   = scan_q + 1'b1;
      ev_vld_d = 1'b1;
      ev_idx_d = scan_q;
    end

    // Evaluate the returned entry
    if (ev_vld_q) begin
      if (ev_hit) begin
        next_d[ev_idx_q] = 1'b1;
        any_d            = 1'b1;
      end
      if (ev_fin) begin
        fh_d = 1'b1;
        fi_d = ev_idx_q;
      end
    end

    // Advance or close the match attempt
    if (state_q == ST_DECIDE) begin
      if (any_q) begin
        cand_d = next_q;
        pos_d  = pos_q + 1'b1;
      end else begin
        if ((pos_q != '0) && fh_q) begin
          found_d = 1'b1;
          fent_d  = fi_q;
        end
        idle_d = 1'b1;
        pos_d  = '0;
      end
    end

    // Result word
    if ((state_q == ST_OUT) && slot_free) begin
      out_vld_d = 1'b1;
      out_d     = {5'd0, 4'(lm_rdata), 5'(fent_q), found_q,
                   (kind_q == REQ_CHECK) && any_q};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cand_q    <= '0;
      pos_q     <= '0;
      idle_q    <= 1'b1;
      found_q   <= 1'b0;
      fent_q    <= '0;
      scan_q    <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cand_q    <= cand_d;
      pos_q     <= pos_d;
      idle_q    <= idle_d;
      found_q   <= found_d;
      fent_q    <= fent_d;
      scan_q    <= scan_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    idx_q    <= idx_d;
    lpos_q   <= lpos_d;
    ch_q     <= ch_d;
    llen_q   <= llen_d;
    next_q   <= next_d;
    any_q    <= any_d;
    fh_q     <= fh_d;
    fi_q     <= fi_d;
    ev_idx_q <= ev_idx_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
